[rtl/core/bfwm_pkg.sv]
// ----------------------------------------------------------------------------
// bfwm_pkg
// Shared widths, codes and types of the bounded FIFO window mean unit.
// ----------------------------------------------------------------------------
package bfwm_pkg;

  localparam int unsigned YearW     = 14;
  localparam int unsigned TagW      = 16;
  localparam int unsigned YearMax   = (2 ** YearW) - 1;
  localparam int unsigned DepthDef  = 5;

  // command codes carried by the kind field
  localparam logic KindPush = 1'b0;
  localparam logic KindPop  = 1'b1;

  typedef struct packed {
    logic [YearW-1:0] year;
    logic [TagW-1:0]  tag;
  } entry_t;

endpackage

[rtl/core/bfwm_ring.sv]
// ----------------------------------------------------------------------------
// bfwm_ring
// Entry store of the FIFO: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module bfwm_ring #(
  parameter int unsigned DEPTH = bfwm_pkg::DepthDef,
  parameter int unsigned PtrW  = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                clk_i,
  input  logic                wr_en_i,
  input  logic [PtrW-1:0]     wr_addr_i,
  input  bfwm_pkg::entry_t    wr_entry_i,
  input  logic [PtrW-1:0]     rd_addr_i,
  output bfwm_pkg::entry_t    rd_entry_o
);

  bfwm_pkg::entry_t mem_q [DEPTH];
  bfwm_pkg::entry_t rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_entry_i;
    end
    rd_q <= mem_q[rd_addr_i];
  end

  assign rd_entry_o = rd_q;

endmodule

[rtl/core/bfwm_div.sv]
// ----------------------------------------------------------------------------
// bfwm_div
// Bit-serial restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bfwm_div #(
  parameter int unsigned DvdW = 17,
  parameter int unsigned DvsW = 3,
  parameter int unsigned QW   = 14
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [DvdW-1:0] dividend_i,
  input  logic [DvsW-1:0] divisor_i,
  output logic            done_o,
  output logic [QW-1:0]   quotient_o
);

  localparam int unsigned CntW = (DvdW > 1) ? $clog2(DvdW) : 1;

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [DvdW-1:0] dq_q, dq_d;     // dividend shifts out the top, quotient in the bottom
  logic [DvsW-1:0] rem_q, rem_d;
  logic [DvsW-1:0] dvs_q, dvs_d;
  logic [DvsW:0]   trial;
  logic            fits;

  assign trial = {rem_q, dq_q[DvdW-1]};
  assign fits  = (trial >= {1'b0, dvs_q});

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dq_d   = dq_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      dq_d   = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = fits ? DvsW'(trial - {1'b0, dvs_q}) : trial[DvsW-1:0];
      dq_d  = {dq_q[DvdW-2:0], fits};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntW'(DvdW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dq_q  <= dq_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o     = done_q;
  assign quotient_o = dq_q[QW-1:0];

endmodule

[rtl/core/bounded_fifo_window_mean_unit.sv]
// ----------------------------------------------------------------------------
// bounded_fifo_window_mean_unit
// Bounded FIFO of tag/year entries reporting the mean year after each push.
// ----------------------------------------------------------------------------
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  in      | in_valid_i in_ready_o kind_i item_tag_i    | sink
//          | year_i                                    |
//  out     | out_valid_o out_ready_i mean_year_o        | source
//          | popped_tag_o popped_valid_o               |
//
//  a push steps through StRead, StUse, StAppend and StDStart, then waits in
//  StDWait on the bit-serial divider that forms the mean one quotient bit per cycle
//  a pop steps through StRead and StUse: one store read and one update
//  one transaction is worked on at a time; in_ready_o is high when idle,
//  also while a finished result waits on out_ready_i
//  reset clears pointer, count and sum; the store needs no clearing
// ----------------------------------------------------------------------------
module bounded_fifo_window_mean_unit #(
  parameter int unsigned DEPTH = bfwm_pkg::DepthDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       kind_i,
  input  logic [bfwm_pkg::TagW-1:0]  item_tag_i,
  input  logic [bfwm_pkg::YearW-1:0] year_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [bfwm_pkg::YearW-1:0] mean_year_o,
  output logic [bfwm_pkg::TagW-1:0]  popped_tag_o,
  output logic                       popped_valid_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam int unsigned SumW = $clog2(DEPTH * bfwm_pkg::YearMax + 1);

  typedef enum logic [6:0] {
    StIdle   = 7'b0000001,
    StRead   = 7'b0000010,
    StUse    = 7'b0000100,
    StAppend = 7'b0001000,
    StDStart = 7'b0010000,
    StDWait  = 7'b0100000,
    StDone   = 7'b1000000
  } state_e;

  state_e                     state_q, state_d;
  logic [PtrW-1:0]            head_q, head_d;
  logic [CntW-1:0]            count_q, count_d;
  logic [SumW-1:0]            sum_q, sum_d;
  logic                       kind_q;
  logic [bfwm_pkg::TagW-1:0]  tag_q;
  logic [bfwm_pkg::YearW-1:0] year_q;

  logic [bfwm_pkg::YearW-1:0] res_mean_q, res_mean_d;
  logic [bfwm_pkg::TagW-1:0]  res_tag_q, res_tag_d;
  logic                       res_valid_q, res_valid_d;

  logic                       out_valid_q, out_valid_d;
  logic [bfwm_pkg::YearW-1:0] out_mean_q;
  logic [bfwm_pkg::TagW-1:0]  out_tag_q;
  logic                       out_pv_q;

  logic                       accept;
  logic                       load_out;
  logic [PtrW-1:0]            head_next;
  logic [CntW:0]              tail_sum;
  logic [PtrW-1:0]            tail;
  logic                       wr_en;
  bfwm_pkg::entry_t           wr_entry;
  bfwm_pkg::entry_t           rd_entry;
  logic                       div_start;
  logic                       div_done;
  logic [bfwm_pkg::YearW-1:0] quotient;

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == StIdle);
  assign load_out   = (state_q == StDone) && (!out_valid_q || out_ready_i);

  assign head_next = (head_q == PtrW'(DEPTH - 1)) ? '0 : head_q + 1'b1;

  // tail slot: head + count folded once, the sum stays below twice the depth
  assign tail_sum = (CntW + 1)'(head_q) + (CntW + 1)'(count_q);
  assign tail     = (tail_sum >= (CntW + 1)'(DEPTH)) ?
                    PtrW'(tail_sum - (CntW + 1)'(DEPTH)) : PtrW'(tail_sum);

  assign wr_en         = (state_q == StAppend);
  assign wr_entry.year = year_q;
  assign wr_entry.tag  = tag_q;
  assign div_start     = (state_q == StDStart);

  bfwm_ring #(
    .DEPTH (DEPTH),
    .PtrW  (PtrW)
  ) u_ring (
    .clk_i      (clk_i),
    .wr_en_i    (wr_en),
    .wr_addr_i  (tail),
    .wr_entry_i (wr_entry),
    .rd_addr_i  (head_q),
    .rd_entry_o (rd_entry)
  );

  bfwm_div #(
    .DvdW (SumW),
    .DvsW (CntW),
    .QW   (bfwm_pkg::YearW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_q),
    .divisor_i  (count_q),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    count_d     = count_q;
    sum_d       = sum_q;
    res_mean_d  = res_mean_q;
    res_tag_d   = res_tag_q;
    res_valid_d = res_valid_q;
    case (state_q)
      StIdle: begin
        if (accept) begin
          state_d = StRead;
        end
      end
      StRead: begin
        state_d = StUse;
      end
      StUse: begin
        res_mean_d  = '0;
        res_tag_d   = '0;
        res_valid_d = 1'b0;
        if (kind_q == bfwm_pkg::KindPush) begin
          // full: the oldest entry falls out of the window unreported
          if (count_q == CntW'(DEPTH)) begin
            sum_d   = sum_q - SumW'(rd_entry.year);
            head_d  = head_next;
            count_d = count_q - 1'b1;
          end
          state_d = StAppend;
        end else begin
          if (count_q != '0) begin
            res_tag_d   = rd_entry.tag;
            res_valid_d = 1'b1;
            sum_d       = sum_q - SumW'(rd_entry.year);
            head_d      = head_next;
            count_d     = count_q - 1'b1;
          end
          state_d = StDone;
        end
      end
      StAppend: begin
        sum_d   = sum_q + SumW'(year_q);
        count_d = count_q + 1'b1;
        state_d = StDStart;
      end
      StDStart: begin
        state_d = StDWait;
      end
      StDWait: begin
        if (div_done) begin
          res_mean_d = quotient;
          state_d    = StDone;
        end
      end
      StDone: begin
        if (load_out) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (load_out) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      head_q      <= '0;
      count_q     <= '0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      count_q     <= count_d;
      sum_q       <= sum_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q <= kind_i;
      tag_q  <= item_tag_i;
      year_q <= year_i;
    end
    res_mean_q  <= res_mean_d;
    res_tag_q   <= res_tag_d;
    res_valid_q <= res_valid_d;
    if (load_out) begin
      out_mean_q <= res_mean_q;
      out_tag_q  <= res_tag_q;
      out_pv_q   <= res_valid_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign mean_year_o    = out_mean_q;
  assign popped_tag_o   = out_tag_q;
  assign popped_valid_o = out_pv_q;

endmodule

[rtl/core/bfwm_chk.sv]
// ----------------------------------------------------------------------------
// bfwm_chk
// Port-level checks of the bounded FIFO window mean unit.
// ----------------------------------------------------------------------------
module bfwm_chk (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_o,
  input logic                       out_valid_o,
  input logic                       out_ready_i,
  input logic [bfwm_pkg::YearW-1:0] mean_year_o,
  input logic [bfwm_pkg::TagW-1:0]  popped_tag_o,
  input logic                       popped_valid_o
);

  // a held result keeps its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(mean_year_o) && $stable(popped_tag_o)
      && $stable(popped_valid_o))
    else $error("result changed while stalled");

  // a popped entry never carries a mean
  a_pop_no_mean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && popped_valid_o |-> mean_year_o == '0)
    else $error("mean reported on a pop");

  // no entry removed means no tag shown
  a_tag_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !popped_valid_o |-> popped_tag_o == '0)
    else $error("tag shown without a removed entry");

  // one transaction at a time: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while busy");

endmodule

bind bounded_fifo_window_mean_unit bfwm_chk u_bfwm_chk (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_ready_o     (in_ready_o),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .mean_year_o    (mean_year_o),
  .popped_tag_o   (popped_tag_o),
  .popped_valid_o (popped_valid_o)
);

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the bounded FIFO window mean unit: a scoreboard
// keeps its own copy of the five-entry window, predicts the mean year after
// each push and the tag returned by each pop, and compares every result
// transaction in order while both channels are idled and stalled at random.
// ----------------------------------------------------------------------------

class window_mean_scoreboard;

  typedef struct {
    logic [bfwm_pkg::YearW-1:0] mean_year;
    logic [bfwm_pkg::TagW-1:0]  popped_tag;
    logic                       popped_valid;
  } window_result_t;

  logic [bfwm_pkg::YearW-1:0] window_years [bfwm_pkg::DepthDef];
  logic [bfwm_pkg::TagW-1:0]  window_tags  [bfwm_pkg::DepthDef];
  int unsigned                oldest_slot;
  int unsigned                held_count;
  int unsigned                years_total;
  window_result_t             awaited_q [$];

  int unsigned mismatches;
  int unsigned checked;
  int unsigned pushes;
  int unsigned pops;
  int unsigned displaced;
  int unsigned empty_pops;

  function new();
    oldest_slot = 0;
    held_count  = 0;
    years_total = 0;
    mismatches  = 0;
    checked     = 0;
    pushes      = 0;
    pops        = 0;
    displaced   = 0;
    empty_pops  = 0;
  endfunction

  function int unsigned pending();
    return awaited_q.size();
  endfunction

  function void retire_oldest();
    years_total -= window_years[oldest_slot];
    oldest_slot = (oldest_slot + 1) % bfwm_pkg::DepthDef;
    held_count--;
  endfunction

  function void note_input(logic kind, logic [bfwm_pkg::TagW-1:0] tag,
                           logic [bfwm_pkg::YearW-1:0] year);
    window_result_t res;
    int unsigned    tail;
    res.mean_year    = '0;
    res.popped_tag   = '0;
    res.popped_valid = 1'b0;
    if (kind == bfwm_pkg::KindPush) begin
      pushes++;
      // full window: the oldest entry leaves without a report
      if (held_count == bfwm_pkg::DepthDef) begin
        retire_oldest();
        displaced++;
      end
      tail = (oldest_slot + held_count) % bfwm_pkg::DepthDef;
      window_years[tail] = year;
      window_tags[tail]  = tag;
      held_count++;
      years_total += year;
      res.mean_year = bfwm_pkg::YearW'(years_total / held_count);
    end else begin
      pops++;
      if (held_count != 0) begin
        res.popped_tag   = window_tags[oldest_slot];
        res.popped_valid = 1'b1;
        retire_oldest();
      end else begin
        empty_pops++;
      end
    end
    awaited_q.push_back(res);
  endfunction

  function void report_field(string field, int unsigned want, logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 100)
        $display("%0t %s: expected %0d, got %0d", $time, field, want, got);
    end
  endfunction

  function void check_result(logic [bfwm_pkg::YearW-1:0] mean_year,
                             logic [bfwm_pkg::TagW-1:0]  popped_tag,
                             logic                       popped_valid);
    window_result_t want;
    if (awaited_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 100)
        $display("%0t result: expected none, got mean %0d tag %0d valid %0b",
                 $time, mean_year, popped_tag, popped_valid);
      return;
    end
    want = awaited_q.pop_front();
    checked++;
    report_field("mean_year", want.mean_year, 32'(mean_year));
    report_field("popped_tag", want.popped_tag, 32'(popped_tag));
    report_field("popped_valid", want.popped_valid, 32'(popped_valid));
  endfunction

endclass

module tb_top;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned YearTop    = (2 ** bfwm_pkg::YearW) - 1;
  localparam int unsigned TagTop     = (2 ** bfwm_pkg::TagW) - 1;

  logic                       clk;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_ready;
  logic                       kind;
  logic [bfwm_pkg::TagW-1:0]  item_tag;
  logic [bfwm_pkg::YearW-1:0] year;
  logic                       out_valid;
  logic                       out_ready;
  logic [bfwm_pkg::YearW-1:0] mean_year;
  logic [bfwm_pkg::TagW-1:0]  popped_tag;
  logic                       popped_valid;

  window_mean_scoreboard sb;

  int unsigned cycles;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned hold_left;
  logic        hold_req;

  bounded_fifo_window_mean_unit u_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .kind_i         (kind),
    .item_tag_i     (item_tag),
    .year_i         (year),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .mean_year_o    (mean_year),
    .popped_tag_o   (popped_tag),
    .popped_valid_o (popped_valid)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // both channels sampled before this edge's updates land
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready)
        sb.note_input(kind, item_tag, year);
      if (out_valid && out_ready)
        sb.check_result(mean_year, popped_tag, popped_valid);
    end
  end

  // result side: random stalls, plus one long hold-off on request
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req) begin
      hold_req  = 1'b0;
      out_ready <= 1'b0;
      hold_left <= HoldCycles;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic send_item(input logic                       k,
                           input logic [bfwm_pkg::TagW-1:0]  t,
                           input logic [bfwm_pkg::YearW-1:0] y);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    kind     <= k;
    item_tag <= t;
    year     <= y;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  function automatic logic [bfwm_pkg::YearW-1:0] pick_year();
    case ($urandom_range(9))
      0:       return '0;
      1:       return bfwm_pkg::YearW'(YearTop);
      2, 3:    return bfwm_pkg::YearW'($urandom_range(YearTop, 10000));
      default: return bfwm_pkg::YearW'($urandom_range(9999, 0));
    endcase
  endfunction

  function automatic logic [bfwm_pkg::TagW-1:0] pick_tag();
    case ($urandom_range(7))
      0:       return '0;
      1:       return bfwm_pkg::TagW'(TagTop);
      default: return bfwm_pkg::TagW'($urandom_range(TagTop, 0));
    endcase
  endfunction

  // bursts leaning to pushes overflow the window, bursts leaning to pops
  // drain it and run into the empty case
  task automatic random_phase(input int unsigned count, input bit with_hold);
    int unsigned done;
    int unsigned burst;
    int unsigned push_pct;
    done = 0;
    while (done < count) begin
      burst = $urandom_range(16, 4);
      case ($urandom_range(2))
        0:       push_pct = 85;
        1:       push_pct = 50;
        default: push_pct = 15;
      endcase
      repeat (burst) begin
        if (with_hold && done == 40)
          hold_req = 1'b1;
        send_item(($urandom_range(99) < push_pct) ? bfwm_pkg::KindPush
                                                  : bfwm_pkg::KindPop,
                  pick_tag(), pick_year());
        done++;
      end
    end
  endtask

  initial begin
    sb             = new();
    cycles         = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_left      = 0;
    hold_req       = 1'b0;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    kind           = bfwm_pkg::KindPush;
    item_tag       = '0;
    year           = '0;
    out_ready      = 1'b0;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty pop, field extremes, overflow, drain past empty
    send_item(bfwm_pkg::KindPop, 16'hFFFF, 14'h3FFF);
    send_item(bfwm_pkg::KindPush, '0, '0);
    send_item(bfwm_pkg::KindPush, 16'hFFFF, 14'h3FFF);
    send_item(bfwm_pkg::KindPush, 16'h5A5A, 14'd9999);
    send_item(bfwm_pkg::KindPush, 16'hA5A5, 14'd1);
    send_item(bfwm_pkg::KindPush, 16'h0001, 14'h3FFF);
    send_item(bfwm_pkg::KindPush, 16'h8000, 14'h3FFF);
    send_item(bfwm_pkg::KindPush, 16'h7FFF, 14'h3FFF);
    send_item(bfwm_pkg::KindPush, 16'h1234, 14'h3FFF);
    send_item(bfwm_pkg::KindPush, 16'hFEDC, 14'h3FFF);
    send_item(bfwm_pkg::KindPush, 16'h0F0F, 14'h3FFF);
    repeat (6) send_item(bfwm_pkg::KindPop, '0, '0);
    send_item(bfwm_pkg::KindPush, 16'h2A2A, 14'd2000);
    send_item(bfwm_pkg::KindPush, 16'h1515, 14'd2001);
    send_item(bfwm_pkg::KindPop, 16'hFFFF, 14'h3FFF);
    send_item(bfwm_pkg::KindPush, 16'h3C3C, 14'd7);
    send_item(bfwm_pkg::KindPop, '0, '0);
    send_item(bfwm_pkg::KindPop, '0, '0);
    send_item(bfwm_pkg::KindPop, '0, '0);

    random_phase(280, 1'b1);
    send_idle_pct  = 75;
    recv_stall_pct = 0;
    random_phase(280, 1'b0);
    send_idle_pct  = 0;
    recv_stall_pct = 75;
    random_phase(280, 1'b0);
    send_idle_pct  = 36;
    recv_stall_pct = 36;
    random_phase(285, 1'b0);

    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (60) @(posedge clk);

    $display("covered %0d pushes (%0d displacing the oldest entry) and %0d pops",
             sb.pushes, sb.displaced, sb.pops);
    $display("%0d pops found the window empty; %0d results checked, %0d mismatches",
             sb.empty_pops, sb.checked, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
